>>> src/kbdp_pkg.sv
package kbdp_pkg;

  localparam int OP_W   = 2;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 8;
  localparam int CNT_W  = 9;
  localparam int BITS_W = 4;
  localparam int CLS_W  = 2;
  localparam int TOT_W  = 7;
  localparam int ENT_W  = 18;
  localparam int MAP_W  = 256;
  localparam int ROW_W  = CNT_W + MAP_W;

  localparam logic [OP_W-1:0] OP_OBSERVE   = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY_POS = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY_SUM = 2'd2;

  localparam logic [CLS_W-1:0] CLS_LOW  = 2'd0;
  localparam logic [CLS_W-1:0] CLS_MID  = 2'd1;
  localparam logic [CLS_W-1:0] CLS_HIGH = 2'd2;

  localparam int unsigned LOW_LIMIT = 16;
  localparam int unsigned MID_LIMIT = 64;
  localparam int unsigned CNT_MAX   = 256;

  localparam logic [ENT_W-1:0] ENT_MAX = 18'h3FFFF;

  // log2(d) with fb fraction bits by repeated squaring, rounded half up
  function automatic logic [31:0] fixed_log2(input int unsigned d, input int unsigned fb);
    int unsigned n;
    int unsigned i;
    logic [63:0] x;
    logic [63:0] frac;
    logic [63:0] r;
    n    = 0;
    frac = '0;
    if (d < 2) begin
      return '0;
    end
    while ((d >> (n + 1)) != 0) begin
      n++;
    end
    x = (64'(d) << 30) >> n;
    for (i = 0; i <= fb; i++) begin
      x    = (x * x) >> 30;
      frac = frac << 1;
      if (x >= (64'd1 << 31)) begin
        x    = x >> 1;
        frac = frac | 64'd1;
      end
    end
    r = (64'(n) << (fb + 1)) | frac;
    return 32'((r + 64'd1) >> 1);
  endfunction

endpackage

>>> src/kbdp_if.sv
interface kbdp_in_if import kbdp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [POS_W-1:0] key_position;
  logic [VAL_W-1:0] byte_value;

  modport source(output valid, opcode, key_position, byte_value, input ready);
  modport sink(input valid, opcode, key_position, byte_value, output ready);
endinterface

interface kbdp_out_if import kbdp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  report_position;
  logic [CNT_W-1:0]  distinct_count;
  logic [BITS_W-1:0] bits_needed;
  logic [CLS_W-1:0]  entropy_class;
  logic [TOT_W-1:0]  low_total;
  logic [TOT_W-1:0]  mid_total;
  logic [TOT_W-1:0]  high_total;
  logic [ENT_W-1:0]  entropy_bits_q8;

  modport source(output valid, report_position, distinct_count, bits_needed, entropy_class,
                 low_total, mid_total, high_total, entropy_bits_q8, input ready);
  modport sink(input valid, report_position, distinct_count, bits_needed, entropy_class,
               low_total, mid_total, high_total, entropy_bits_q8, output ready);
endinterface

>>> src/key_byte_distinct_profiler_unit.sv
// channel   dir  handshake        payload
// in_if     in   valid/ready      opcode, key_position, byte_value
// out_if    out  valid/ready      report_position .. entropy_bits_q8 (queries only)
//
// One beat per cycle while out_if is not stalled; a query result reaches out_if through
// stage 1, stage 2 and the output register. The rate is set by the single read-modify-write
// loop on the position row memory, closed by forwarding the last written row.
// Reset clears all per-position valid bits together; no clearing pass, ready right away.
// out_if.ready low with a result held freezes the whole pipe and drops in_if.ready.
module key_byte_distinct_profiler_unit import kbdp_pkg::*; #(
  parameter int KEY_BYTES     = 66,
  parameter int FRACTION_BITS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  kbdp_in_if.sink         in_if,
  kbdp_out_if.source      out_if
);

  localparam int AW    = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int TW    = $clog2(KEY_BYTES + 1);
  localparam int DW    = FRACTION_BITS + 1;
  localparam int SUM_W = $clog2(KEY_BYTES * 8 * (2 ** FRACTION_BITS) + 1);
  localparam int OW    = (SUM_W > ENT_W) ? SUM_W : ENT_W;

  typedef logic [DW-1:0] delta_tab_t [256];

  function automatic delta_tab_t build_delta();
    delta_tab_t t;
    for (int c = 0; c < 256; c++) begin
      t[c] = DW'(fixed_log2(c + 1, FRACTION_BITS) - fixed_log2(c, FRACTION_BITS));
    end
    return t;
  endfunction

  localparam delta_tab_t DELTA = build_delta();

  // position rows: {count, seen map}
  logic [ROW_W-1:0] row_mem [KEY_BYTES];
  logic [ROW_W-1:0] rd_q_r;
  logic [KEY_BYTES-1:0] row_vld_r;

  logic adv;

  // accept side
  logic [POS_W+AW-1:0] in_pos_ext;
  logic [AW-1:0]       in_addr;
  logic                in_rng;

  // stage 1
  logic             s1_vld_r;
  logic [OP_W-1:0]  s1_op_r;
  logic [POS_W-1:0] s1_pos_r;
  logic [AW-1:0]    s1_addr_r;
  logic [VAL_W-1:0] s1_val_r;
  logic             s1_rng_r;

  logic             fwd_vld_r;
  logic [AW-1:0]    fwd_addr_r;
  logic [ROW_W-1:0] fwd_row_r;

  logic             fwd_hit;
  logic [ROW_W-1:0] row_cur;
  logic [MAP_W-1:0] map_cur;
  logic [CNT_W-1:0] cnt_cur;
  logic             seen;
  logic             bump;
  logic             wr_en;
  logic [ROW_W-1:0] wr_row;

  // stage 2
  logic             s2_vld_r;
  logic [OP_W-1:0]  s2_op_r;
  logic [POS_W-1:0] s2_pos_r;
  logic [CNT_W-1:0] s2_cnt_r;
  logic             s2_upd_r;

  logic [BITS_W-1:0] s2_bits;
  logic [CLS_W-1:0]  s2_cls;
  logic [CNT_W-1:0]  cnt_m1;

  // totals
  logic [TW-1:0]    low_r, low_nxt;
  logic [TW-1:0]    mid_r, mid_nxt;
  logic [TW-1:0]    high_r, high_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  logic [TW+TOT_W-1:0] low_ext, mid_ext, high_ext;
  logic [OW-1:0]       sum_ext;
  logic [ENT_W-1:0]    sum_sat;

  // output register
  logic              out_vld_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic [BITS_W-1:0] out_bits_r;
  logic [CLS_W-1:0]  out_cls_r;
  logic [TOT_W-1:0]  out_low_r;
  logic [TOT_W-1:0]  out_mid_r;
  logic [TOT_W-1:0]  out_high_r;
  logic [ENT_W-1:0]  out_ent_r;

  assign adv         = !out_vld_r || out_if.ready;
  assign in_if.ready = adv;

  assign in_pos_ext = (POS_W + AW)'(in_if.key_position);
  assign in_addr    = in_pos_ext[AW-1:0];
  assign in_rng     = (32'(in_if.key_position) < 32'(KEY_BYTES));

  // memory
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_q_r <= row_mem[in_addr];
    end
    if (wr_en) begin
      row_mem[s1_addr_r] <= wr_row;
    end
  end

  // stage 1: modify
  always_comb begin
    fwd_hit = fwd_vld_r && (fwd_addr_r == s1_addr_r);
    if (fwd_hit) begin
      row_cur = fwd_row_r;
    end else if (s1_rng_r && row_vld_r[s1_addr_r]) begin
      row_cur = rd_q_r;
    end else begin
      row_cur = '0;
    end
    map_cur = row_cur[MAP_W-1:0];
    cnt_cur = row_cur[ROW_W-1 -: CNT_W];
    seen    = map_cur[s1_val_r];
    bump    = (cnt_cur < CNT_W'(CNT_MAX));
    wr_en   = adv && s1_vld_r && (s1_op_r == OP_OBSERVE) && s1_rng_r && !seen;
    wr_row  = {bump ? CNT_W'(cnt_cur + CNT_W'(1)) : cnt_cur,
               map_cur | (MAP_W'(1) << s1_val_r)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      fwd_vld_r <= 1'b0;
      row_vld_r <= '0;
    end else if (adv) begin
      s1_vld_r  <= in_if.valid;
      s2_vld_r  <= s1_vld_r;
      fwd_vld_r <= wr_en;
      if (wr_en) begin
        row_vld_r[s1_addr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r    <= in_if.opcode;
      s1_pos_r   <= in_if.key_position;
      s1_addr_r  <= in_addr;
      s1_val_r   <= in_if.byte_value;
      s1_rng_r   <= in_rng;
      fwd_addr_r <= s1_addr_r;
      fwd_row_r  <= wr_row;
      s2_op_r    <= s1_op_r;
      s2_pos_r   <= s1_pos_r;
      s2_cnt_r   <= s1_rng_r ? cnt_cur : '0;
      s2_upd_r   <= wr_en && bump;
    end
  end

  // stage 2: report fields and totals
  always_comb begin
    cnt_m1  = s2_cnt_r - CNT_W'(1);
    s2_bits = '0;
    if (s2_cnt_r > CNT_W'(1)) begin
      for (int i = 0; i < CNT_W; i++) begin
        if (cnt_m1[i]) begin
          s2_bits = BITS_W'(i + 1);
        end
      end
    end
    if (s2_cnt_r <= CNT_W'(LOW_LIMIT)) begin
      s2_cls = CLS_LOW;
    end else if (s2_cnt_r <= CNT_W'(MID_LIMIT)) begin
      s2_cls = CLS_MID;
    end else begin
      s2_cls = CLS_HIGH;
    end
  end

  always_comb begin
    low_nxt  = low_r;
    mid_nxt  = mid_r;
    high_nxt = high_r;
    sum_nxt  = sum_r;
    if (adv && s2_vld_r && s2_upd_r) begin
      sum_nxt = sum_r + SUM_W'(DELTA[s2_cnt_r[7:0]]);
      if (s2_cnt_r == CNT_W'(LOW_LIMIT)) begin
        low_nxt = low_r - TW'(1);
        mid_nxt = mid_r + TW'(1);
      end else if (s2_cnt_r == CNT_W'(MID_LIMIT)) begin
        mid_nxt  = mid_r - TW'(1);
        high_nxt = high_r + TW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= TW'(KEY_BYTES);
      mid_r  <= '0;
      high_r <= '0;
      sum_r  <= '0;
    end else begin
      low_r  <= low_nxt;
      mid_r  <= mid_nxt;
      high_r <= high_nxt;
      sum_r  <= sum_nxt;
    end
  end

  assign low_ext  = (TW + TOT_W)'(low_r);
  assign mid_ext  = (TW + TOT_W)'(mid_r);
  assign high_ext = (TW + TOT_W)'(high_r);
  assign sum_ext  = OW'(sum_r);
  assign sum_sat  = (sum_ext > OW'(ENT_MAX)) ? ENT_MAX : sum_ext[ENT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s2_vld_r && ((s2_op_r == OP_QUERY_POS) || (s2_op_r == OP_QUERY_SUM));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s2_op_r == OP_QUERY_POS) begin
        out_pos_r  <= s2_pos_r;
        out_cnt_r  <= s2_cnt_r;
        out_bits_r <= s2_bits;
        out_cls_r  <= s2_cls;
        out_low_r  <= '0;
        out_mid_r  <= '0;
        out_high_r <= '0;
        out_ent_r  <= '0;
      end else begin
        out_pos_r  <= '0;
        out_cnt_r  <= '0;
        out_bits_r <= '0;
        out_cls_r  <= CLS_LOW;
        out_low_r  <= low_ext[TOT_W-1:0];
        out_mid_r  <= mid_ext[TOT_W-1:0];
        out_high_r <= high_ext[TOT_W-1:0];
        out_ent_r  <= sum_sat;
      end
    end
  end

  assign out_if.valid           = out_vld_r;
  assign out_if.report_position = out_pos_r;
  assign out_if.distinct_count  = out_cnt_r;
  assign out_if.bits_needed     = out_bits_r;
  assign out_if.entropy_class   = out_cls_r;
  assign out_if.low_total       = out_low_r;
  assign out_if.mid_total       = out_mid_r;
  assign out_if.high_total      = out_high_r;
  assign out_if.entropy_bits_q8 = out_ent_r;

`ifndef SYNTHESIS
  // every position sits in exactly one class
  a_tally_conserved: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(low_r) + 32'(mid_r) + 32'(high_r)) == 32'(KEY_BYTES))
    else $error("class tallies do not add up to the position count");

  // entropy sum never decreases
  a_sum_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (sum_r >= $past(sum_r)))
    else $error("entropy sum decreased");

  // a row write always leaves that position marked valid
  a_row_valid_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> row_vld_r[$past(s1_addr_r)])
    else $error("written row not marked valid");
`endif

endmodule
